FILE: hw/rtl/scd_pkg.sv
package scd_pkg;

  localparam int unsigned DATA_W = 64;

  localparam logic [DATA_W-1:0] GOLDEN_SALT   = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [DATA_W-1:0] GOLDEN_TWICE  = 64'h3C6E_F372_FE94_F82A;
  localparam logic [DATA_W-1:0] DISTRICT_SALT = 64'hD1B5_4A32_D192_ED03;
  localparam logic [DATA_W-1:0] ROUTE_SALT    = 64'h94D0_49BB_1331_11EB;
  localparam logic [DATA_W-1:0] CLUSTER_SALT  = 64'hF135_7AEA_2E62_A9C5;
  localparam logic [DATA_W-1:0] OBJECT_SALT   = 64'hC2B2_AE3D_27D4_EB4F;
  localparam logic [DATA_W-1:0] MULT_A        = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [DATA_W-1:0] MULT_B        = 64'h94D0_49BB_1331_11EB;

  // Segments per cluster is four, so the cluster index is a shift by two.
  localparam int unsigned SEG_SHIFT = 2;

  localparam int unsigned MIX_LAT    = 5;
  localparam int unsigned MIX_GROUPS = 12;
  localparam int unsigned PIPE_LAT   = MIX_GROUPS * MIX_LAT;

endpackage

FILE: hw/rtl/scd_delay.sv
module scd_delay #(
  parameter int unsigned WIDTH = scd_pkg::DATA_W,
  parameter int unsigned DEPTH = scd_pkg::MIX_LAT
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    taps[0] <= din;
    for (int i = 1; i < DEPTH; i++) begin
      taps[i] <= taps[i-1];
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

FILE: hw/rtl/scd_mix.sv
module scd_mix (
  input  logic                       clk,
  input  logic [scd_pkg::DATA_W-1:0] in_a,
  input  logic [scd_pkg::DATA_W-1:0] in_b,
  input  logic [scd_pkg::DATA_W-1:0] addend,
  output logic [scd_pkg::DATA_W-1:0] mix_out
);

  localparam logic [31:0] A_LO = scd_pkg::MULT_A[31:0];
  localparam logic [31:0] A_HI = scd_pkg::MULT_A[63:32];
  localparam logic [31:0] B_LO = scd_pkg::MULT_B[31:0];
  localparam logic [31:0] B_HI = scd_pkg::MULT_B[63:32];

  logic [63:0] sum;
  logic [63:0] y;
  logic [63:0] a_ll;
  logic [31:0] a_lh;
  logic [31:0] a_hl;
  logic [63:0] p;
  logic [63:0] z;
  logic [63:0] b_ll;
  logic [31:0] b_lh;
  logic [31:0] b_hl;
  logic [63:0] q;
  logic [63:0] prod_ll_a;
  logic [63:0] prod_lh_a;
  logic [63:0] prod_hl_a;
  logic [63:0] prod_ll_b;
  logic [63:0] prod_lh_b;
  logic [63:0] prod_hl_b;

  assign sum = (in_a ^ in_b) + addend;

  assign prod_ll_a = y[31:0] * A_LO;
  assign prod_lh_a = y[31:0] * A_HI;
  assign prod_hl_a = y[63:32] * A_LO;
  assign p = a_ll + {a_lh + a_hl, 32'h0000_0000};

  assign prod_ll_b = z[31:0] * B_LO;
  assign prod_lh_b = z[31:0] * B_HI;
  assign prod_hl_b = z[63:32] * B_LO;
  assign q = b_ll + {b_lh + b_hl, 32'h0000_0000};

  always_ff @(posedge clk) begin
    y       <= sum ^ (sum >> 30);
    a_ll    <= prod_ll_a;
    a_lh    <= prod_lh_a[31:0];
    a_hl    <= prod_hl_a[31:0];
    z       <= p ^ (p >> 27);
    b_ll    <= prod_ll_b;
    b_lh    <= prod_lh_b[31:0];
    b_hl    <= prod_hl_b[31:0];
    mix_out <= q ^ (q >> 31);
  end

endmodule

FILE: hw/rtl/splitmix_seed_chain_deriver.sv
// Derives the district, route, cluster and object seeds of one key request.
// A request is taken at a rising edge with start high and busy low; busy is
// high only while rst is high, so one request can be taken in every cycle.
// The base seed is written through cfg_we and cfg_wdata and must only change
// while no request is in flight.
// Each result appears on the hash ports for one cycle with done high, and
// results leave in request order.
// The pipeline depth is set by the twelve chained mixer passes of the object
// chain, five register stages each: every 64-bit multiply is split into
// 32-bit partial products in one stage and summed in the next. Throughput
// is one request per cycle.
// The receiver has no way to stall the block; done is a one-cycle strobe.
// Synchronous reset drops every request in flight and sets the base seed to
// zero.
module splitmix_seed_chain_deriver (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  input  logic [63:0] route_family,
  input  logic [63:0] bundle_template,
  input  logic [7:0]  connection_class,
  input  logic [7:0]  flow_class,
  input  logic [31:0] segment_number,
  input  logic [31:0] lane_number,
  input  logic [7:0]  object_class,
  input  logic [31:0] ordinal_number,
  input  logic        start_flag,
  output logic        done,
  output logic [63:0] district_hash,
  output logic [63:0] route_hash,
  output logic [63:0] cluster_hash,
  output logic [63:0] object_hash
);

  localparam int unsigned L = scd_pkg::MIX_LAT;
  localparam int unsigned PL = scd_pkg::PIPE_LAT;
  localparam logic [63:0] G1 = scd_pkg::GOLDEN_SALT;
  localparam logic [63:0] G2 = scd_pkg::GOLDEN_TWICE;
  localparam logic [63:0] ZERO = 64'h0;

  logic [63:0] base_seed;
  logic [PL-1:0] vld;
  logic accept;

  logic [63:0] fam_d, bun_d, seg_d, lane_d, ord_d;
  logic [7:0] cc_d, fc_d, oc_d;
  logic start_d;
  logic [63:0] seg4_w;

  logic [63:0] i_dis, i_rte, i_fam, i_bun, i_cc, i_fc, i_cs, i_os;
  logic [63:0] i_seg4, i_seg, i_lane, i_oc, i_ord, i_start;
  logic [63:0] district, r1, r2, r3, r4, route, c1, cluster;
  logic [63:0] o1, o2, o3, o4, o5;

  assign busy = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_seed <= ZERO;
    end else if (cfg_we) begin
      base_seed <= cfg_wdata;
    end
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PL-2:0], accept};
    end
  end

  assign done = vld[PL-1];

  scd_delay #(.WIDTH(64), .DEPTH(1 * L)) u_dly_fam (
    .clk(clk), .din(route_family), .dout(fam_d));
  scd_delay #(.WIDTH(64), .DEPTH(2 * L)) u_dly_bun (
    .clk(clk), .din(bundle_template), .dout(bun_d));
  scd_delay #(.WIDTH(8), .DEPTH(3 * L)) u_dly_cc (
    .clk(clk), .din(connection_class), .dout(cc_d));
  scd_delay #(.WIDTH(8), .DEPTH(4 * L)) u_dly_fc (
    .clk(clk), .din(flow_class), .dout(fc_d));
  scd_delay #(.WIDTH(64), .DEPTH(6 * L)) u_dly_seg (
    .clk(clk), .din({32'h0, segment_number}), .dout(seg_d));
  scd_delay #(.WIDTH(64), .DEPTH(7 * L)) u_dly_lane (
    .clk(clk), .din({32'h0, lane_number}), .dout(lane_d));
  scd_delay #(.WIDTH(8), .DEPTH(8 * L)) u_dly_oc (
    .clk(clk), .din(object_class), .dout(oc_d));
  scd_delay #(.WIDTH(64), .DEPTH(9 * L)) u_dly_ord (
    .clk(clk), .din({32'h0, ordinal_number}), .dout(ord_d));
  scd_delay #(.WIDTH(1), .DEPTH(10 * L)) u_dly_start (
    .clk(clk), .din(start_flag), .dout(start_d));

  assign seg4_w = seg_d >> scd_pkg::SEG_SHIFT;

  // Each field value is premixed one pass ahead of the chain step using it.
  scd_mix u_i_dis (.clk(clk), .in_a(scd_pkg::DISTRICT_SALT), .in_b(ZERO),
    .addend(G2), .mix_out(i_dis));
  scd_mix u_i_rte (.clk(clk), .in_a(scd_pkg::ROUTE_SALT), .in_b(ZERO),
    .addend(G2), .mix_out(i_rte));
  scd_mix u_i_fam (.clk(clk), .in_a(fam_d), .in_b(ZERO),
    .addend(G2), .mix_out(i_fam));
  scd_mix u_i_bun (.clk(clk), .in_a(bun_d), .in_b(ZERO),
    .addend(G2), .mix_out(i_bun));
  scd_mix u_i_cc (.clk(clk), .in_a({56'h0, cc_d}), .in_b(ZERO),
    .addend(G2), .mix_out(i_cc));
  scd_mix u_i_fc (.clk(clk), .in_a({56'h0, fc_d}), .in_b(ZERO),
    .addend(G2), .mix_out(i_fc));
  scd_mix u_i_cs (.clk(clk), .in_a(scd_pkg::CLUSTER_SALT), .in_b(ZERO),
    .addend(G2), .mix_out(i_cs));
  scd_mix u_i_os (.clk(clk), .in_a(scd_pkg::OBJECT_SALT), .in_b(ZERO),
    .addend(G2), .mix_out(i_os));
  scd_mix u_i_seg4 (.clk(clk), .in_a(seg4_w), .in_b(ZERO),
    .addend(G2), .mix_out(i_seg4));
  scd_mix u_i_seg (.clk(clk), .in_a(seg_d), .in_b(ZERO),
    .addend(G2), .mix_out(i_seg));
  scd_mix u_i_lane (.clk(clk), .in_a(lane_d), .in_b(ZERO),
    .addend(G2), .mix_out(i_lane));
  scd_mix u_i_oc (.clk(clk), .in_a({56'h0, oc_d}), .in_b(ZERO),
    .addend(G2), .mix_out(i_oc));
  scd_mix u_i_ord (.clk(clk), .in_a(ord_d), .in_b(ZERO),
    .addend(G2), .mix_out(i_ord));
  scd_mix u_i_start (.clk(clk), .in_a({63'h0, start_d}), .in_b(ZERO),
    .addend(G2), .mix_out(i_start));

  scd_mix u_o_dis (.clk(clk), .in_a(base_seed), .in_b(i_dis),
    .addend(G1), .mix_out(district));
  scd_mix u_o_r1 (.clk(clk), .in_a(district), .in_b(i_rte),
    .addend(G1), .mix_out(r1));
  scd_mix u_o_r2 (.clk(clk), .in_a(r1), .in_b(i_fam),
    .addend(G1), .mix_out(r2));
  scd_mix u_o_r3 (.clk(clk), .in_a(r2), .in_b(i_bun),
    .addend(G1), .mix_out(r3));
  scd_mix u_o_r4 (.clk(clk), .in_a(r3), .in_b(i_cc),
    .addend(G1), .mix_out(r4));
  scd_mix u_o_rte (.clk(clk), .in_a(r4), .in_b(i_fc),
    .addend(G1), .mix_out(route));
  scd_mix u_o_c1 (.clk(clk), .in_a(route), .in_b(i_cs),
    .addend(G1), .mix_out(c1));
  scd_mix u_o_cl (.clk(clk), .in_a(c1), .in_b(i_seg4),
    .addend(G1), .mix_out(cluster));
  scd_mix u_o_o1 (.clk(clk), .in_a(route), .in_b(i_os),
    .addend(G1), .mix_out(o1));
  scd_mix u_o_o2 (.clk(clk), .in_a(o1), .in_b(i_seg),
    .addend(G1), .mix_out(o2));
  scd_mix u_o_o3 (.clk(clk), .in_a(o2), .in_b(i_lane),
    .addend(G1), .mix_out(o3));
  scd_mix u_o_o4 (.clk(clk), .in_a(o3), .in_b(i_oc),
    .addend(G1), .mix_out(o4));
  scd_mix u_o_o5 (.clk(clk), .in_a(o4), .in_b(i_ord),
    .addend(G1), .mix_out(o5));
  scd_mix u_o_obj (.clk(clk), .in_a(o5), .in_b(i_start),
    .addend(G1), .mix_out(object_hash));

  scd_delay #(.WIDTH(64), .DEPTH(11 * L)) u_dly_dis (
    .clk(clk), .din(district), .dout(district_hash));
  scd_delay #(.WIDTH(64), .DEPTH(6 * L)) u_dly_rte (
    .clk(clk), .din(route), .dout(route_hash));
  scd_delay #(.WIDTH(64), .DEPTH(4 * L)) u_dly_cl (
    .clk(clk), .din(cluster), .dout(cluster_hash));

endmodule

FILE: hw/rtl/scd_checker.sv
module scd_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        cfg_we,
  input logic [63:0] cfg_wdata,
  input logic        done
);

  localparam int unsigned PL = scd_pkg::PIPE_LAT;

  a_reset_clears: assert property (@(posedge clk) rst |=> !done)
    else $error("done raised right after reset");

  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PL))
    else $error("done without a matching request");

  a_request_completes: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PL done)
    else $error("request lost in the pipeline");

  a_cfg_known: assert property (@(posedge clk) disable iff (rst)
    cfg_we |-> !$isunknown(cfg_wdata))
    else $error("base seed written with unknown data");

endmodule

bind splitmix_seed_chain_deriver scd_checker u_scd_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .cfg_we(cfg_we),
  .cfg_wdata(cfg_wdata),
  .done(done)
);

FILE: sim/tb_splitmix_seed_chain_deriver.sv
module tb_splitmix_seed_chain_deriver;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] GOLDEN_ADD  = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] DISTRICT_K  = 64'hD1B5_4A32_D192_ED03;
  localparam logic [63:0] ROUTE_K     = 64'h94D0_49BB_1331_11EB;
  localparam logic [63:0] CLUSTER_K   = 64'hF135_7AEA_2E62_A9C5;
  localparam logic [63:0] OBJECT_K    = 64'hC2B2_AE3D_27D4_EB4F;
  localparam logic [63:0] FINAL_MUL_1 = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] FINAL_MUL_2 = 64'h94D0_49BB_1331_11EB;

  localparam int NUM_PHASES    = 6;
  localparam int NUM_DIRECTED  = 16;
  localparam int RANDOM_PER_PH = 320;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_WAIT    = scd_pkg::PIPE_LAT + 8;

  typedef struct packed {
    logic [63:0] family;
    logic [63:0] bundle;
    logic [7:0]  conn;
    logic [7:0]  flow;
    logic [31:0] segment;
    logic [31:0] lane;
    logic [7:0]  obj;
    logic [31:0] ordinal;
    logic        at_start;
  } key_t;

  typedef struct packed {
    logic [63:0] district;
    logic [63:0] route;
    logic [63:0] cluster;
    logic [63:0] object;
  } seeds_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        cfg_we;
  logic [63:0] cfg_wdata;
  logic [63:0] route_family;
  logic [63:0] bundle_template;
  logic [7:0]  connection_class;
  logic [7:0]  flow_class;
  logic [31:0] segment_number;
  logic [31:0] lane_number;
  logic [7:0]  object_class;
  logic [31:0] ordinal_number;
  logic        start_flag;
  logic        done;
  logic [63:0] district_hash;
  logic [63:0] route_hash;
  logic [63:0] cluster_hash;
  logic [63:0] object_hash;

  seeds_t      pending_seeds[$];
  logic [63:0] base_seed_shadow;
  int          errors;
  int          cycles;

  key_t directed_keys [NUM_DIRECTED] = '{
    {64'h0, 64'h0, 8'h00, 8'h00, 32'h0, 32'h0, 8'h00, 32'h0, 1'b0},
    {{64{1'b1}}, {64{1'b1}}, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
     32'hFFFF_FFFF, 1'b1},
    {{64{1'b1}}, 64'h0, 8'h00, 8'h00, 32'h0, 32'h0, 8'h00, 32'h0, 1'b0},
    {64'h0, {64{1'b1}}, 8'h00, 8'h00, 32'h0, 32'h0, 8'h00, 32'h0, 1'b0},
    {64'h0, 64'h0, 8'hFF, 8'h00, 32'h0, 32'h0, 8'h00, 32'h0, 1'b0},
    {64'h0, 64'h0, 8'h00, 8'hFF, 32'h0, 32'h0, 8'h00, 32'h0, 1'b0},
    {64'h0, 64'h0, 8'h00, 8'h00, 32'h1, 32'h0, 8'h00, 32'h0, 1'b0},
    {64'h0, 64'h0, 8'h00, 8'h00, 32'h3, 32'h0, 8'h00, 32'h0, 1'b0},
    {64'h0, 64'h0, 8'h00, 8'h00, 32'h4, 32'h0, 8'h00, 32'h0, 1'b0},
    {64'h0, 64'h0, 8'h00, 8'h00, 32'hFFFF_FFFF, 32'h0, 8'h00, 32'h0, 1'b0},
    {64'h0, 64'h0, 8'h00, 8'h00, 32'h0, 32'hFFFF_FFFF, 8'h00, 32'h0, 1'b0},
    {64'h0, 64'h0, 8'h00, 8'h00, 32'h0, 32'h0, 8'hFF, 32'h0, 1'b0},
    {64'h0, 64'h0, 8'h00, 8'h00, 32'h0, 32'h0, 8'h00, 32'hFFFF_FFFF, 1'b0},
    {64'h0, 64'h0, 8'h00, 8'h00, 32'h0, 32'h0, 8'h00, 32'h0, 1'b1},
    {64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 8'h55, 8'hAA, 32'h5555_5555,
     32'hAAAA_AAAA, 8'h55, 32'hAAAA_AAAA, 1'b1},
    {64'h1, 64'h1, 8'h01, 8'h01, 32'h1, 32'h1, 8'h01, 32'h1, 1'b1}
  };

  splitmix_seed_chain_deriver uut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .route_family     (route_family),
    .bundle_template  (bundle_template),
    .connection_class (connection_class),
    .flow_class       (flow_class),
    .segment_number   (segment_number),
    .lane_number      (lane_number),
    .object_class     (object_class),
    .ordinal_number   (ordinal_number),
    .start_flag       (start_flag),
    .done             (done),
    .district_hash    (district_hash),
    .route_hash       (route_hash),
    .cluster_hash     (cluster_hash),
    .object_hash      (object_hash)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] splitmix_finalize(input logic [63:0] x);
    logic [63:0] z;
    z = x + GOLDEN_ADD;
    z = (z ^ (z >> 30)) * FINAL_MUL_1;
    z = (z ^ (z >> 27)) * FINAL_MUL_2;
    return z ^ (z >> 31);
  endfunction

  function automatic logic [63:0] chain_seed(input logic [63:0] s, input logic [63:0] v);
    return splitmix_finalize(s ^ splitmix_finalize(v + GOLDEN_ADD));
  endfunction

  function automatic seeds_t derive_seeds(input logic [63:0] root, input key_t k);
    seeds_t      r;
    logic [63:0] acc;
    r.district = chain_seed(root, DISTRICT_K);
    acc = chain_seed(r.district, ROUTE_K);
    acc = chain_seed(acc, k.family);
    acc = chain_seed(acc, k.bundle);
    acc = chain_seed(acc, {56'd0, k.conn});
    r.route = chain_seed(acc, {56'd0, k.flow});
    acc = chain_seed(r.route, CLUSTER_K);
    r.cluster = chain_seed(acc, {32'd0, k.segment} >> 2);
    acc = chain_seed(r.route, OBJECT_K);
    acc = chain_seed(acc, {32'd0, k.segment});
    acc = chain_seed(acc, {32'd0, k.lane});
    acc = chain_seed(acc, {56'd0, k.obj});
    acc = chain_seed(acc, {32'd0, k.ordinal});
    r.object = chain_seed(acc, {63'd0, k.at_start});
    return r;
  endfunction

  function automatic logic [63:0] pick_value();
    int unsigned mode;
    mode = $urandom_range(0, 9);
    case (mode)
      0: return 64'h0;
      1: return {64{1'b1}};
      2: return 64'($urandom_range(0, 15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic key_t random_key();
    key_t        k;
    logic [63:0] v;
    k.family = pick_value();
    k.bundle = pick_value();
    v = pick_value();
    k.conn = v[7:0];
    v = pick_value();
    k.flow = v[7:0];
    v = pick_value();
    k.segment = v[31:0];
    v = pick_value();
    k.lane = v[31:0];
    v = pick_value();
    k.obj = v[7:0];
    v = pick_value();
    k.ordinal = v[31:0];
    k.at_start = 1'($urandom_range(0, 1));
    return k;
  endfunction

  task automatic report_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    seeds_t exp_s;
    key_t   k;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_splitmix_seed_chain_deriver: done, errors");
      $finish;
    end
    if (rst) begin
      base_seed_shadow = 64'h0;
    end else begin
      if (done) begin
        if (pending_seeds.size() == 0) begin
          errors++;
          $display("%0t: result with no request outstanding, got %h %h %h %h", $time,
                   district_hash, route_hash, cluster_hash, object_hash);
        end else begin
          exp_s = pending_seeds.pop_front();
          report_field("district_hash", exp_s.district, district_hash);
          report_field("route_hash", exp_s.route, route_hash);
          report_field("cluster_hash", exp_s.cluster, cluster_hash);
          report_field("object_hash", exp_s.object, object_hash);
        end
      end
      if (start && !busy) begin
        k = '{route_family, bundle_template, connection_class, flow_class,
              segment_number, lane_number, object_class, ordinal_number, start_flag};
        pending_seeds.push_back(derive_seeds(base_seed_shadow, k));
      end
      if (cfg_we) base_seed_shadow = cfg_wdata;
    end
  end

  task automatic send_request(input key_t k, input int idle_pct);
    @(negedge clk);
    route_family     = k.family;
    bundle_template  = k.bundle;
    connection_class = k.conn;
    flow_class       = k.flow;
    segment_number   = k.segment;
    lane_number      = k.lane;
    object_class     = k.obj;
    ordinal_number   = k.ordinal;
    start_flag       = k.at_start;
    start            = 1'b1;
    do @(posedge clk); while (busy);
    if ($urandom_range(1, 100) <= idle_pct) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
  endtask

  task automatic write_base_seed(input logic [63:0] value);
    while (pending_seeds.size() != 0) @(posedge clk);
    @(negedge clk);
    start     = 1'b0;
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  initial begin
    int          idle_pcts [NUM_PHASES];
    logic [63:0] seed_value;
    idle_pcts        = '{0, 53, 38, 0, 53, 38};
    errors           = 0;
    cycles           = 0;
    rst              = 1'b1;
    start            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = 64'h0;
    route_family     = 64'h0;
    bundle_template  = 64'h0;
    connection_class = 8'h0;
    flow_class       = 8'h0;
    segment_number   = 32'h0;
    lane_number      = 32'h0;
    object_class     = 8'h0;
    ordinal_number   = 32'h0;
    start_flag       = 1'b0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // The first phase runs on the base seed left by reset; each later one
    // drains every request in flight and then loads a new base seed.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        1: seed_value = {64{1'b1}};
        3: seed_value = 64'h1;
        4: seed_value = 64'h8000_0000_0000_0000;
        default: seed_value = {$urandom, $urandom};
      endcase
      if (ph != 0) write_base_seed(seed_value);
      for (int i = 0; i < NUM_DIRECTED; i++) send_request(directed_keys[i], idle_pcts[ph]);
      for (int i = 0; i < RANDOM_PER_PH; i++) send_request(random_key(), idle_pcts[ph]);
      @(negedge clk);
      start = 1'b0;
    end

    while (pending_seeds.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("tb_splitmix_seed_chain_deriver: done, clean");
    end else begin
      $display("tb_splitmix_seed_chain_deriver: done, errors");
    end
    $finish;
  end

endmodule
